// ----- hdl/cv3a_pkg.sv -----
// Shared types and constants for the checked int64 vector3 ALU.
// No dependencies; imported by the lane, the top level and the testbench files.
`default_nettype none

package cv3a_pkg;

    // Operation codes; codes 6 and 7 are undefined and flag an error
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4,
        CMD_DOT = 3'd5
    } cmd_t;

    localparam logic [63:0] MOST_NEG_64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

    // Register stages inside one lane, and in the whole pipeline
    localparam int LANE_STAGES = 35;
    localparam int PIPE_STAGES = LANE_STAGES + 2;

    // One lane result as it leaves the lane
    typedef struct packed {
        logic [63:0] res;
        logic        bad;
        logic [63:0] a;
        cmd_t        cmd;
    } lane_out_t;

endpackage

`default_nettype wire

// ----- hdl/cv3a_lane.sv -----
// One vector component: checked add, subtract, negate, multiply and divide.
// Depends on cv3a_pkg; stage enables come from the top level.
`default_nettype none

module cv3a_lane
    import cv3a_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [LANE_STAGES-1:0] en,
    input  wire cmd_t                   cmd,
    input  wire logic [63:0]            a,
    input  wire logic [63:0]            b,
    output lane_out_t                   lo
);

    // One radix-2 restoring step; returns {remainder, quotient shift}
    function automatic logic [127:0] div_step(input logic [63:0] rem,
                                              input logic [63:0] quo,
                                              input logic [63:0] dv);
        logic [64:0] t;
        logic        qb;
        t  = {rem, quo[63]};
        qb = 1'b0;
        if (t >= {1'b0, dv})
        begin
            t  = t - {1'b0, dv};
            qb = 1'b1;
        end
        return {t[63:0], quo[62:0], qb};
    endfunction

    // Early results for add, subtract and negate
    logic [63:0] sum, dif, neg, early_res, ma, mb;
    logic        add_ovf, sub_ovf, neg_bad, early_bad, div_bad;

    always_comb
    begin
        sum     = a + b;
        dif     = a - b;
        neg     = 64'd0 - a;
        add_ovf = (a[63] == b[63]) && (sum[63] != a[63]);
        sub_ovf = (a[63] != b[63]) && (dif[63] != a[63]);
        neg_bad = (a == MOST_NEG_64);
        div_bad = (b == 64'd0) || ((a == MOST_NEG_64) && (b == INT64_NEG_ONE));
        ma      = a[63] ? neg : a;
        mb      = b[63] ? (64'd0 - b) : b;
        case (cmd)
            CMD_ADD:
            begin
                early_res = sum;
                early_bad = add_ovf;
            end
            CMD_SUB:
            begin
                early_res = dif;
                early_bad = sub_ovf;
            end
            default:
            begin
                early_res = neg;
                early_bad = neg_bad;
            end
        endcase
    end

    // Carry lines from stage 0 up to stage 33
    cmd_t        cmd_reg  [0:33];
    logic [63:0] a_reg    [0:33];
    logic [63:0] er_reg   [0:33];
    logic        eb_reg   [0:33];
    logic        db_reg   [0:33];
    logic        sg_reg   [0:32];

    // Divider state: stage 0 holds the magnitudes, stages 1..32 iterate
    logic [63:0] rem_reg  [0:32];
    logic [63:0] quo_reg  [0:32];
    logic [63:0] dv_reg   [0:32];
    logic [63:0] qres_reg;

    // Multiplier stages
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [65:0] mid_reg;
    logic [31:0] plo_reg;
    logic [63:0] phi_reg;
    logic [63:0] ml_reg;
    logic        mo_reg;
    logic [63:0] mres_reg [4:33];
    logic        mbad_reg [4:33];

    // Stage 0 capture
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cmd_reg[0] <= cmd;
            a_reg[0]   <= a;
            er_reg[0]  <= early_res;
            eb_reg[0]  <= early_bad;
            db_reg[0]  <= div_bad;
            sg_reg[0]  <= a[63] ^ b[63];
            rem_reg[0] <= 64'd0;
            quo_reg[0] <= ma;
            dv_reg[0]  <= mb;
        end
    end

    // Advance the carry lines
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= 33; k++)
        begin
            if (en[k])
            begin
                cmd_reg[k] <= cmd_reg[k-1];
                a_reg[k]   <= a_reg[k-1];
                er_reg[k]  <= er_reg[k-1];
                eb_reg[k]  <= eb_reg[k-1];
                db_reg[k]  <= db_reg[k-1];
            end
        end
        for (int k = 1; k <= 32; k++)
        begin
            if (en[k])
            begin
                sg_reg[k] <= sg_reg[k-1];
            end
        end
    end

    // Divider iterations, two quotient bits per stage
    logic [127:0] s1 [1:32];
    logic [127:0] s2 [1:32];

    for (genvar g = 1; g <= 32; g++)
    begin : g_div
        assign s1[g] = div_step(rem_reg[g-1], quo_reg[g-1], dv_reg[g-1]);
        assign s2[g] = div_step(s1[g][127:64], s1[g][63:0], dv_reg[g-1]);

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                rem_reg[g] <= s2[g][127:64];
                quo_reg[g] <= s2[g][63:0];
                dv_reg[g]  <= dv_reg[g-1];
            end
        end
    end

    // Apply the quotient sign
    always_ff @(posedge clk)
    begin
        if (en[33])
        begin
            qres_reg <= sg_reg[32] ? (64'd0 - quo_reg[32]) : quo_reg[32];
        end
    end

    // Multiplier: partial products, middle sum, high word and overflow, sign
    logic [65:0] mid_next;
    logic [63:0] phi_next;
    logic [63:0] ml_next;
    logic        mo_next;

    always_comb
    begin
        mid_next = {34'd0, p00_reg[63:32]} + {2'd0, p01_reg} + {2'd0, p10_reg};
        phi_next = phi_reg + {30'd0, mid_reg[65:32]};
        ml_next  = {mid_reg[31:0], plo_reg};
        if (sg_reg[2])
        begin
            mo_next = (phi_next != 64'd0) || (ml_next[63] && (ml_next[62:0] != 63'd0));
        end
        else
        begin
            mo_next = (phi_next != 64'd0) || ml_next[63];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p00_reg <= quo_reg[0][31:0]  * dv_reg[0][31:0];
            p01_reg <= quo_reg[0][31:0]  * dv_reg[0][63:32];
            p10_reg <= quo_reg[0][63:32] * dv_reg[0][31:0];
            p11_reg <= quo_reg[0][63:32] * dv_reg[0][63:32];
        end
        if (en[2])
        begin
            mid_reg <= mid_next;
            plo_reg <= p00_reg[31:0];
            phi_reg <= p11_reg;
        end
        if (en[3])
        begin
            ml_reg <= ml_next;
            mo_reg <= mo_next;
        end
        if (en[4])
        begin
            mres_reg[4] <= sg_reg[3] ? (64'd0 - ml_reg) : ml_reg;
            mbad_reg[4] <= mo_reg;
        end
        for (int k = 5; k <= 33; k++)
        begin
            if (en[k])
            begin
                mres_reg[k] <= mres_reg[k-1];
                mbad_reg[k] <= mbad_reg[k-1];
            end
        end
    end

    // Pick the result for the operation
    lane_out_t lo_next, lo_reg;

    always_comb
    begin
        lo_next.a   = a_reg[33];
        lo_next.cmd = cmd_reg[33];
        case (cmd_reg[33]) inside
            CMD_ADD, CMD_SUB, CMD_NEG:
            begin
                lo_next.res = er_reg[33];
                lo_next.bad = eb_reg[33];
            end
            CMD_MUL, CMD_DOT:
            begin
                lo_next.res = mres_reg[33];
                lo_next.bad = mbad_reg[33];
            end
            CMD_DIV:
            begin
                lo_next.res = qres_reg;
                lo_next.bad = db_reg[33];
            end
            default:
            begin
                lo_next.res = a_reg[33];
                lo_next.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[LANE_STAGES-1])
        begin
            lo_reg <= lo_next;
        end
    end

    assign lo = lo_reg;

endmodule

`default_nettype wire

// ----- hdl/checked_int64_vector3_alu_top.sv -----
// Top level of the checked int64 vector3 ALU: three lanes, dot-product sum, flow control.
// Depends on cv3a_pkg and cv3a_lane.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   cmd, a_x, a_y, a_z, b_x, b_y, b_z
//   output   out_valid / out_ready out_x, out_y, out_z, dot_value, status
//
// The pipeline has 37 register stages from input transfer to output valid; it takes
// one item per cycle while out_ready keeps the last stage moving.
// The 32-stage divider (two quotient bits per stage) sets the depth.
// Reset clears only the stage valid bits. Each stage moves when the stage after it
// is empty or moving, so bubbles close up and a waiting result still lets items in.
`default_nettype none

module checked_int64_vector3_alu_top
    import cv3a_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [63:0] a_x,
    input  wire logic signed [63:0] a_y,
    input  wire logic signed [63:0] a_z,
    input  wire logic signed [63:0] b_x,
    input  wire logic signed [63:0] b_y,
    input  wire logic signed [63:0] b_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      out_x,
    output logic signed [63:0]      out_y,
    output logic signed [63:0]      out_z,
    output logic signed [63:0]      dot_value,
    output logic                    status
);

    localparam int LAST = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] en;

    // Stage enables: load when empty or when the next stage moves
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Component lanes
    lane_out_t lx, ly, lz;

    cv3a_lane u_lane_x (
        .clk (clk),
        .en  (en[LANE_STAGES-1:0]),
        .cmd (cmd_t'(cmd)),
        .a   (a_x),
        .b   (b_x),
        .lo  (lx)
    );

    cv3a_lane u_lane_y (
        .clk (clk),
        .en  (en[LANE_STAGES-1:0]),
        .cmd (cmd_t'(cmd)),
        .a   (a_y),
        .b   (b_y),
        .lo  (ly)
    );

    cv3a_lane u_lane_z (
        .clk (clk),
        .en  (en[LANE_STAGES-1:0]),
        .cmd (cmd_t'(cmd)),
        .a   (a_z),
        .b   (b_z),
        .lo  (lz)
    );

    // Partial dot sum x+y with its own overflow check
    logic [63:0] sxy;
    logic        sxy_ovf, is_dot0, bad0_next;

    always_comb
    begin
        sxy       = lx.res + ly.res;
        sxy_ovf   = (lx.res[63] == ly.res[63]) && (sxy[63] != lx.res[63]);
        is_dot0   = (lx.cmd == CMD_DOT);
        bad0_next = lx.bad || ly.bad || lz.bad || (is_dot0 && sxy_ovf);
    end

    logic [63:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg, rz_reg, sxy_reg;
    logic        dot_reg, bad0_reg;

    always_ff @(posedge clk)
    begin
        if (en[LANE_STAGES])
        begin
            ax_reg   <= lx.a;
            ay_reg   <= ly.a;
            az_reg   <= lz.a;
            rx_reg   <= lx.res;
            ry_reg   <= ly.res;
            rz_reg   <= lz.res;
            sxy_reg  <= sxy;
            dot_reg  <= is_dot0;
            bad0_reg <= bad0_next;
        end
    end

    // Add the z product and select the final result
    logic [63:0] dsum;
    logic        bad1, keep_a;

    always_comb
    begin
        dsum   = sxy_reg + rz_reg;
        bad1   = bad0_reg
                 || (dot_reg && (sxy_reg[63] == rz_reg[63]) && (dsum[63] != sxy_reg[63]));
        keep_a = bad1 || dot_reg;
    end

    logic [63:0] ox_reg, oy_reg, oz_reg, od_reg;
    logic        st_reg;

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            ox_reg <= keep_a ? ax_reg : rx_reg;
            oy_reg <= keep_a ? ay_reg : ry_reg;
            oz_reg <= keep_a ? az_reg : rz_reg;
            od_reg <= (dot_reg && !bad1) ? dsum : 64'd0;
            st_reg <= bad1;
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign dot_value = od_reg;
    assign status    = st_reg;

endmodule

`default_nettype wire

// ----- tb/cv3a_checker.sv -----
// Scoreboard for the checked int64 vector3 ALU: watches both channels, predicts, compares.
// Depends on cv3a_pkg for the operation codes and int64 constants.
`default_nettype none

module cv3a_checker
    import cv3a_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [63:0] a_x,
    input  wire logic signed [63:0] a_y,
    input  wire logic signed [63:0] a_z,
    input  wire logic signed [63:0] b_x,
    input  wire logic signed [63:0] b_y,
    input  wire logic signed [63:0] b_z,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [63:0] out_x,
    input  wire logic signed [63:0] out_y,
    input  wire logic signed [63:0] out_z,
    input  wire logic signed [63:0] dot_value,
    input  wire logic               status,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] dot;
        logic        bad;
    } vec_result_t;

    vec_result_t alu_results[$];

    // Exact signed arithmetic in 130 bits, then a range test against int64
    function automatic logic fits64(logic signed [129:0] v);
        return v >= $signed({{66{1'b1}}, MOST_NEG_64}) &&
               v <= $signed({66'd0, ~MOST_NEG_64});
    endfunction

    function automatic logic signed [129:0] wide(logic [63:0] v);
        return $signed({{66{v[63]}}, v});
    endfunction

    function automatic vec_result_t compute_alu(logic [2:0] op, logic [63:0] ax, logic [63:0] ay,
                                               logic [63:0] az, logic [63:0] bx,
                                               logic [63:0] by, logic [63:0] bz);
        logic [63:0] av [3];
        logic [63:0] bv [3];
        logic [63:0] rv [3];
        logic signed [129:0] e;
        logic signed [129:0] sum;
        logic [63:0] qa;
        logic [63:0] qb;
        logic [63:0] q;
        vec_result_t r;
        logic bad;
        av = '{ax, ay, az};
        bv = '{bx, by, bz};
        rv = '{64'd0, 64'd0, 64'd0};
        bad = 1'b0;
        r.dot = '0;
        case (op)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_NEG:
                for (int i = 0; i < 3; i++)
                begin
                    case (op)
                        CMD_ADD: e = wide(av[i]) + wide(bv[i]);
                        CMD_SUB: e = wide(av[i]) - wide(bv[i]);
                        CMD_MUL: e = wide(av[i]) * wide(bv[i]);
                        default: e = -wide(av[i]);
                    endcase
                    if (!fits64(e)) bad = 1'b1;
                    rv[i] = e[63:0];
                end
            CMD_DIV:
                for (int i = 0; i < 3; i++)
                begin
                    if (bv[i] == 0 || (av[i] == MOST_NEG_64 && bv[i] == INT64_NEG_ONE))
                        bad = 1'b1;
                    else
                    begin
                        qa = av[i][63] ? -av[i] : av[i];
                        qb = bv[i][63] ? -bv[i] : bv[i];
                        q = qa / qb;
                        rv[i] = (av[i][63] ^ bv[i][63]) ? -q : q;
                    end
                end
            CMD_DOT:
            begin
                sum = '0;
                for (int i = 0; i < 3; i++)
                begin
                    e = wide(av[i]) * wide(bv[i]);
                    if (!fits64(e)) bad = 1'b1;
                    // partial sums are checked after each addition
                    if (i > 0)
                    begin
                        sum = wide(sum[63:0]) + wide(e[63:0]);
                        if (!fits64(sum)) bad = 1'b1;
                    end
                    else
                        sum = wide(e[63:0]);
                end
                r.dot = sum[63:0];
                rv = av;
            end
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            rv = av;
            r.dot = '0;
        end
        r.x = rv[0];
        r.y = rv[1];
        r.z = rv[2];
        r.bad = bad;
        return r;
    endfunction

    // Predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        vec_result_t want;
        vec_result_t got;
        if (rst_n && in_valid && in_ready)
            alu_results.push_back(compute_alu(cmd, a_x, a_y, a_z, b_x, b_y, b_z));
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_x, out_y, out_z, dot_value, status};
            if (alu_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", got);
            end
            else
            begin
                want = alu_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h dot=%h st=%b",
                                 want.x, want.y, want.z, want.dot, want.bad,
                                 " got x=%h y=%h z=%h dot=%h st=%b",
                                 got.x, got.y, got.z, got.dot, got.bad);
                end
            end
        end
        pending = alu_results.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
    end
endmodule

`default_nettype wire

// ----- tb/tb_checked_int64_vector3_alu_top.sv -----
// Stimulus and verdict for the checked int64 vector3 ALU.
// Depends on cv3a_pkg, checked_int64_vector3_alu_top and cv3a_checker.
`default_nettype none

module tb_checked_int64_vector3_alu_top;
    import cv3a_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1330;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] cmd;
    logic signed [63:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic out_valid;
    logic out_ready;
    logic signed [63:0] out_x, out_y, out_z, dot_value;
    logic status;
    int errors;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    longint cycles;

    checked_int64_vector3_alu_top DUT (.*);
    cv3a_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_checked_int64_vector3_alu_top: done, errors");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Operand choice that favors edge values
    function automatic logic [63:0] pick_operand(int mode);
        case (mode)
            0: return MOST_NEG_64;
            1: return ~MOST_NEG_64;
            2: return INT64_NEG_ONE;
            3: return 64'd0;
            4: return 64'd1;
            5: return {$urandom, $urandom};
            6: return 64'($signed($urandom_range(4000)) - 2000);
            7: return {{33{1'b0}}, 31'($urandom)};
            8: return {{32{1'b1}}, $urandom};
            default: return {$urandom, $urandom} >>> $urandom_range(63);
        endcase
    endfunction

    // Present one item and hold it until the transfer; valid stays up for the next item
    task automatic send_item(logic [2:0] op, logic [63:0] ax, logic [63:0] ay, logic [63:0] az,
                             logic [63:0] bx, logic [63:0] by, logic [63:0] bz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        {a_x, a_y, a_z, b_x, b_y, b_z} <= {ax, ay, az, bx, by, bz};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [63:0] v [6];
        op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        for (int i = 0; i < 6; i++)
            v[i] = pick_operand($urandom_range(14));
        send_item(op, v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial
    begin
        logic [63:0] big;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cmd = '0;
        {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, extremes, each error case
        big = 64'h0000_0001_0000_0000;
        send_item(CMD_ADD, 1, -5, 7, 2, 3, -9);
        send_item(CMD_ADD, ~MOST_NEG_64, 0, 0, 1, 0, 0);
        send_item(CMD_ADD, 0, 0, MOST_NEG_64, 0, 0, INT64_NEG_ONE);
        send_item(CMD_SUB, 10, -3, 0, 4, 8, ~MOST_NEG_64);
        send_item(CMD_SUB, MOST_NEG_64, 0, 0, 1, 0, 0);
        send_item(CMD_SUB, 0, 0, 0, 0, MOST_NEG_64, 0);
        send_item(CMD_MUL, -3, 7, big - 1, 5, -6, 2);
        send_item(CMD_MUL, big, 1, 1, big, 1, 1);
        send_item(CMD_MUL, MOST_NEG_64, 1, 1, 1, 1, 1);
        send_item(CMD_MUL, MOST_NEG_64, 1, 1, INT64_NEG_ONE, 1, 1);
        send_item(CMD_DIV, 7, -7, MOST_NEG_64, 2, 2, 3);
        send_item(CMD_DIV, 5, 1, 1, 0, 1, 1);
        send_item(CMD_DIV, 1, MOST_NEG_64, 1, 1, INT64_NEG_ONE, 1);
        send_item(CMD_DIV, ~MOST_NEG_64, MOST_NEG_64, -9, INT64_NEG_ONE, MOST_NEG_64, 4);
        send_item(CMD_NEG, 5, ~MOST_NEG_64, 0, 1, 2, 3);
        send_item(CMD_NEG, 1, 2, MOST_NEG_64, 0, 0, 0);
        send_item(CMD_DOT, 1, 2, 3, 4, 5, 6);
        send_item(CMD_DOT, big, 0, 0, big, 0, 0);
        // partial sum overflows although the full sum fits
        send_item(CMD_DOT, ~MOST_NEG_64, 1, INT64_NEG_ONE, 1, 1, 1);
        send_item(CMD_DOT, ~MOST_NEG_64, 0, 1, 1, 0, 1);
        send_item(CMD_DOT, MOST_NEG_64, 0, 0, INT64_NEG_ONE, 0, 0);
        send_item(3'd6, 1, 2, 3, 4, 5, 6);
        send_item(3'd7, MOST_NEG_64, ~MOST_NEG_64, 0, 0, 0, 0);
        in_valid <= 1'b0;

        // Pause until drained
        while (pending != 0)
            @(negedge clk);

        // Random phases with varied idling
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case (n % 500)
                0:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                100: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                200: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                300: begin send_idle_pct = 19; recv_stall_pct = 19; end
                400:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // long receiver hold-off so the pipeline fills and stalls input
                    hold_off = 150;
                end
                default: ;
            endcase
            send_random();
        end
        in_valid <= 1'b0;

        // Drain, then allow for the pipeline depth
        recv_stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_STAGES + 10) @(negedge clk);
        if (errors == 0)
            $display("tb_checked_int64_vector3_alu_top: done, clean");
        else
            $display("tb_checked_int64_vector3_alu_top: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
